/* src/normalized_landmark_error_macros.svh */
// Assertion helpers for the checker file.
`ifndef NORMALIZED_LANDMARK_ERROR_MACROS_SVH
`define NORMALIZED_LANDMARK_ERROR_MACROS_SVH

// Checked only outside reset.
`define NLE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");

// Checked on every edge, reset included.
`define NLE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("check failed");

`endif

/* src/nle_pkg.sv */
package nle_pkg;

  localparam int DIV_W  = 64;
  localparam int DVS_W  = 36;
  localparam int SQ_W   = 72;
  localparam int ROOT_W = 36;

  localparam logic [47:0] CAP48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] CAP32 = 32'hFFFF_FFFF;

  localparam logic [1:0] CFG_LANDMARK_COUNT = 2'd0;
  localparam logic [1:0] CFG_LEFT_MASK      = 2'd1;
  localparam logic [1:0] CFG_RIGHT_MASK     = 2'd2;

  typedef struct packed {
    logic signed [19:0] true_x;
    logic signed [19:0] true_y;
    logic signed [19:0] pred_x;
    logic signed [19:0] pred_y;
    logic               final_shape;
  } landmark_t;

  typedef struct packed {
    logic [31:0] mean_error;
    logic [20:0] shapes_seen;
    logic        degenerate_seen;
  } result_t;

  typedef struct packed {
    logic [6:0]  count;
    logic [63:0] left_mask;
    logic [63:0] right_mask;
  } cfg_t;

  // One classified landmark waiting for the back end.
  typedef struct packed {
    logic [40:0]        sq;
    logic signed [19:0] tx;
    logic signed [19:0] ty;
    logic               left;
    logic               right;
    logic               last;
    logic               fin;
  } fq_item_t;

endpackage

/* src/nle_front.sv */
module nle_front (
  input  logic              clk,
  input  logic              rst,
  input  nle_pkg::landmark_t landmark,
  input  logic              push,
  output logic              full,
  input  nle_pkg::cfg_t     cfg,
  output nle_pkg::fq_item_t q_item,
  output logic              q_valid,
  input  logic              q_pop
);
  import nle_pkg::*;

  localparam int DEPTH = 4;

  logic [6:0]         pos;
  logic               accept;
  logic               last_now;
  logic [20:0]        diff_x, diff_y;
  logic               a_valid;
  logic [19:0]        a_dx, a_dy;
  logic signed [19:0] a_tx, a_ty;
  logic               a_left, a_right, a_last, a_fin;
  fq_item_t           a_item;
  fq_item_t           fifo [DEPTH];
  logic [1:0]         wr_ptr, rd_ptr;
  logic [2:0]         count;
  logic               do_pop;

  assign accept   = push && !full;
  assign last_now = (8'(pos) + 8'd1) >= 8'(cfg.count);
  assign diff_x   = 21'(landmark.true_x) - 21'(landmark.pred_x);
  assign diff_y   = 21'(landmark.true_y) - 21'(landmark.pred_y);
  assign full     = (4'(count) + 4'(a_valid)) >= 4'(DEPTH);
  assign do_pop   = q_pop && (count != 3'd0);

  always_comb begin
    a_item.sq    = 41'(a_dx * a_dx) + 41'(a_dy * a_dy);
    a_item.tx    = a_tx;
    a_item.ty    = a_ty;
    a_item.left  = a_left;
    a_item.right = a_right;
    a_item.last  = a_last;
    a_item.fin   = a_fin;
  end

  assign q_item  = fifo[rd_ptr];
  assign q_valid = count != 3'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      a_valid <= 1'b0;
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
    end else begin
      a_valid <= accept;
      if (accept) begin
        pos     <= last_now ? 7'd0 : pos + 7'd1;
        a_dx    <= diff_x[20] ? 20'(-diff_x) : diff_x[19:0];
        a_dy    <= diff_y[20] ? 20'(-diff_y) : diff_y[19:0];
        a_tx    <= landmark.true_x;
        a_ty    <= landmark.true_y;
        a_left  <= cfg.left_mask[pos[5:0]];
        a_right <= cfg.right_mask[pos[5:0]];
        a_last  <= last_now;
        a_fin   <= landmark.final_shape;
      end
      if (a_valid) begin
        fifo[wr_ptr] <= a_item;
        wr_ptr       <= wr_ptr + 2'd1;
      end
      if (do_pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(a_valid) - 3'(do_pop);
    end
  end

endmodule

/* src/nle_div.sv */
module nle_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [nle_pkg::DIV_W-1:0] dividend,
  input  logic [nle_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [nle_pkg::DIV_W-1:0] quotient
);
  import nle_pkg::*;

  logic             busy;
  logic [6:0]       cnt;
  logic [DIV_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   trial;

  assign trial = {rem, dvd[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        dvd      <= dividend;
        dvs      <= divisor;
        rem      <= '0;
        quotient <= '0;
        cnt      <= 7'(DIV_W);
        busy     <= 1'b1;
        done     <= 1'b0;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem      <= DVS_W'(trial - {1'b0, dvs});
          quotient <= {quotient[DIV_W-2:0], 1'b1};
        end else begin
          rem      <= trial[DVS_W-1:0];
          quotient <= {quotient[DIV_W-2:0], 1'b0};
        end
        dvd <= dvd << 1;
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

/* src/nle_sqrt.sv */
module nle_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [nle_pkg::SQ_W-1:0]   value,
  input  logic [5:0]                 steps,
  output logic                       done,
  output logic [nle_pkg::ROOT_W-1:0] root
);
  import nle_pkg::*;

  logic            busy;
  logic [5:0]      cnt;
  logic [SQ_W-1:0] v, r, bitpos, trial;
  logic [6:0]      shamt;

  // The first trial bit is 4^(steps-1); the value must stay below 4^steps.
  assign shamt = {steps - 6'd1, 1'b0};
  assign trial = r + bitpos;
  assign root  = r[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        v      <= value;
        r      <= '0;
        bitpos <= SQ_W'(1) << shamt;
        cnt    <= steps;
        busy   <= 1'b1;
        done   <= 1'b0;
      end else if (busy) begin
        if (v >= trial) begin
          v <= v - trial;
          r <= (r >> 1) + bitpos;
        end else begin
          r <= r >> 1;
        end
        bitpos <= bitpos >> 2;
        cnt    <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

/* src/nle_back.sv */
module nle_back #(
  parameter int MAX_LANDMARKS = 64,
  parameter int MAX_SHAPES    = 1048576
) (
  input  logic              clk,
  input  logic              rst,
  input  nle_pkg::cfg_t     cfg,
  input  nle_pkg::fq_item_t q_item,
  input  logic              q_valid,
  output logic              q_pop,
  output nle_pkg::result_t  result,
  output logic              out_valid,
  input  logic              out_pop
);
  import nle_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LSQRT, ST_COUNT, ST_CHECK, ST_CDIV, ST_CWAIT, ST_DIFF, ST_MUL,
    ST_PSQRT, ST_PWAIT, ST_QWAIT, ST_FINISH, ST_PROD, ST_MDIV, ST_MWAIT, ST_EMIT
  } state_t;

  state_t             state;
  fq_item_t           cur;
  logic signed [26:0] lsx, lsy, rsx, rsy;
  logic [28:0]        sds;
  logic [47:0]        total;
  logic [20:0]        counter;
  logic               degen;
  logic [6:0]         idx, nl, nr;
  logic [63:0]        lm_sh, rm_sh;
  logic [1:0]         cidx;
  logic signed [34:0] cen [4];
  logic [34:0]        my;
  logic [SQ_W-1:0]    acc, ma;
  logic [34:0]        mb;
  logic [5:0]         mcnt;
  logic               mph;
  logic [27:0]        prod;
  logic [31:0]        mean_r;

  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dividend, div_q;
  logic [DVS_W-1:0]   div_divisor;
  logic               sq_start, sq_done;
  logic [SQ_W-1:0]    sq_value;
  logic [5:0]         sq_steps;
  logic [ROOT_W-1:0]  sq_root;

  logic signed [26:0] c_sum;
  logic [6:0]         c_cnt;
  logic [26:0]        c_mag;
  logic signed [34:0] c_val;
  logic signed [35:0] dx_s, dy_s;
  logic [47:0]        q_sat;
  logic [48:0]        tot_sum;

  nle_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_q)
  );

  nle_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .value(sq_value), .steps(sq_steps),
    .done(sq_done), .root(sq_root)
  );

  assign q_pop = (state == ST_IDLE) && q_valid;

  always_comb begin
    case (cidx)
      2'd0:    begin c_sum = lsx; c_cnt = nl; end
      2'd1:    begin c_sum = rsx; c_cnt = nr; end
      2'd2:    begin c_sum = lsy; c_cnt = nl; end
      default: begin c_sum = rsy; c_cnt = nr; end
    endcase
    c_mag   = c_sum[26] ? 27'(-c_sum) : c_sum;
    c_val   = c_sum[26] ? -35'(div_q[33:0]) : 35'(div_q[33:0]);
    dx_s    = 36'(cen[0]) - 36'(cen[1]);
    dy_s    = 36'(cen[2]) - 36'(cen[3]);
    q_sat   = (div_q > 64'(CAP48)) ? CAP48 : div_q[47:0];
    tot_sum = 49'(total) + 49'(q_sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lsx       <= '0;
      lsy       <= '0;
      rsx       <= '0;
      rsy       <= '0;
      sds       <= '0;
      total     <= '0;
      counter   <= '0;
      degen     <= 1'b0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      sq_start  <= 1'b0;
    end else begin
      // A pop in the emit state is replaced by the new result below.
      if (out_pop && state != ST_EMIT) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            if (q_item.left) begin
              lsx <= lsx + 27'(q_item.tx);
              lsy <= lsy + 27'(q_item.ty);
            end
            if (q_item.right) begin
              rsx <= rsx + 27'(q_item.tx);
              rsy <= rsy + 27'(q_item.ty);
            end
            sq_value <= SQ_W'({q_item.sq, 4'b0000});
            sq_steps <= 6'd23;
            sq_start <= 1'b1;
            state    <= ST_LSQRT;
          end
        end
        ST_LSQRT: begin
          sq_start <= 1'b0;
          if (sq_done) begin
            sds <= sds + 29'(sq_root);
            if (cur.last) begin
              lm_sh <= cfg.left_mask;
              rm_sh <= cfg.right_mask;
              idx   <= '0;
              nl    <= '0;
              nr    <= '0;
              state <= ST_COUNT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_COUNT: begin
          // Only mask bits below the landmark count are members.
          if (idx < cfg.count) begin
            nl <= nl + 7'(lm_sh[0]);
            nr <= nr + 7'(rm_sh[0]);
          end
          lm_sh <= lm_sh >> 1;
          rm_sh <= rm_sh >> 1;
          idx   <= idx + 7'd1;
          if (idx == 7'(MAX_LANDMARKS - 1)) state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (nl == 7'd0 || nr == 7'd0) begin
            degen <= 1'b1;
            state <= ST_FINISH;
          end else begin
            cidx  <= 2'd0;
            state <= ST_CDIV;
          end
        end
        ST_CDIV: begin
          div_dividend <= DIV_W'({c_mag, 8'h00});
          div_divisor  <= DVS_W'(c_cnt);
          div_start    <= 1'b1;
          state        <= ST_CWAIT;
        end
        ST_CWAIT: begin
          div_start <= 1'b0;
          if (div_done) begin
            cen[cidx] <= c_val;
            if (cidx == 2'd3) begin
              state <= ST_DIFF;
            end else begin
              cidx  <= cidx + 2'd1;
              state <= ST_CDIV;
            end
          end
        end
        ST_DIFF: begin
          my    <= dy_s[35] ? 35'(-dy_s) : dy_s[34:0];
          acc   <= '0;
          mcnt  <= '0;
          mph   <= 1'b0;
          ma    <= SQ_W'(dx_s[35] ? 35'(-dx_s) : dx_s[34:0]);
          mb    <= dx_s[35] ? 35'(-dx_s) : dx_s[34:0];
          state <= ST_MUL;
        end
        ST_MUL: begin
          // Shift-and-add squaring, x first, then y into the same sum.
          if (mb[0]) acc <= acc + ma;
          if (mcnt == 6'd34) begin
            if (!mph) begin
              ma   <= SQ_W'(my);
              mb   <= my;
              mcnt <= '0;
              mph  <= 1'b1;
            end else begin
              state <= ST_PSQRT;
            end
          end else begin
            ma   <= ma << 1;
            mb   <= mb >> 1;
            mcnt <= mcnt + 6'd1;
          end
        end
        ST_PSQRT: begin
          sq_value <= acc;
          sq_steps <= 6'(ROOT_W);
          sq_start <= 1'b1;
          state    <= ST_PWAIT;
        end
        ST_PWAIT: begin
          sq_start <= 1'b0;
          if (sq_done) begin
            if (sq_root == '0) begin
              degen <= 1'b1;
              state <= ST_FINISH;
            end else if (counter < 21'(MAX_SHAPES)) begin
              div_dividend <= DIV_W'({sds, 30'b0});
              div_divisor  <= sq_root;
              div_start    <= 1'b1;
              state        <= ST_QWAIT;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_QWAIT: begin
          div_start <= 1'b0;
          if (div_done) begin
            total   <= tot_sum[48] ? CAP48 : tot_sum[47:0];
            counter <= counter + 21'd1;
            state   <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          lsx <= '0;
          lsy <= '0;
          rsx <= '0;
          rsy <= '0;
          sds <= '0;
          if (!cur.fin) begin
            state <= ST_IDLE;
          end else if (counter == '0) begin
            mean_r <= '0;
            state  <= ST_EMIT;
          end else begin
            state <= ST_PROD;
          end
        end
        ST_PROD: begin
          prod  <= 28'(cfg.count * counter);
          state <= ST_MDIV;
        end
        ST_MDIV: begin
          div_dividend <= DIV_W'(total);
          div_divisor  <= DVS_W'(prod);
          div_start    <= 1'b1;
          state        <= ST_MWAIT;
        end
        ST_MWAIT: begin
          div_start <= 1'b0;
          if (div_done) begin
            mean_r <= (div_q > 64'(CAP32)) ? CAP32 : div_q[31:0];
            state  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid || out_pop) begin
            result.mean_error      <= mean_r;
            result.shapes_seen     <= counter;
            result.degenerate_seen <= degen;
            out_valid              <= 1'b1;
            total                  <= '0;
            counter                <= '0;
            degen                  <= 1'b0;
            state                  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/normalized_landmark_error.sv */
// Channel     Direction  Handshake         Payload
// landmark    in         push / full       landmark_t: truth and prediction, final flag
// result      out        pop / empty       result_t: mean error, shapes, degenerate flag
// config      in         cfg_write         cfg_index selects the register, cfg_data
//
// Each landmark runs a 23-step square root in the back end. A shape's last landmark
// adds a mask count, four centre divisions, squaring, a 36-step root and one more
// division, with the later steps skipped for a degenerate shape.
// A set's last shape adds the mean division unless no shape was counted.
// Reset is synchronous; four landmarks queue between front and back, so push is
// taken while the back end works and a result waits in its own register for pop.
module normalized_landmark_error #(
  parameter int MAX_LANDMARKS = 64,
  parameter int MAX_SHAPES    = 1048576
) (
  input  logic               clk,
  input  logic               rst,
  input  nle_pkg::landmark_t landmark,
  input  logic               push,
  output logic               full,
  output nle_pkg::result_t   result,
  output logic               empty,
  input  logic               pop,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import nle_pkg::*;

  logic [6:0]  landmark_count;
  logic [63:0] left_pupil_mask, right_pupil_mask;
  cfg_t        cfg;
  fq_item_t    q_item;
  logic        q_valid, q_pop, out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      landmark_count   <= 7'd64;
      left_pupil_mask  <= 64'd1;
      right_pupil_mask <= 64'd2;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LANDMARK_COUNT: landmark_count   <= cfg_data[6:0];
        CFG_LEFT_MASK:      left_pupil_mask  <= cfg_data;
        CFG_RIGHT_MASK:     right_pupil_mask <= cfg_data;
        default:            ;
      endcase
    end
  end

  always_comb begin
    if (landmark_count == 7'd0) cfg.count = 7'd1;
    else if (landmark_count > 7'(MAX_LANDMARKS)) cfg.count = 7'(MAX_LANDMARKS);
    else cfg.count = landmark_count;
    cfg.left_mask  = left_pupil_mask;
    cfg.right_mask = right_pupil_mask;
  end

  assign empty = !out_valid;

  nle_front u_front (
    .clk(clk), .rst(rst), .landmark(landmark), .push(push), .full(full), .cfg(cfg),
    .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
  );

  nle_back #(.MAX_LANDMARKS(MAX_LANDMARKS), .MAX_SHAPES(MAX_SHAPES)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop),
    .result(result), .out_valid(out_valid), .out_pop(pop && out_valid)
  );

endmodule

/* src/nle_checker.sv */
`include "normalized_landmark_error_macros.svh"

module nle_checker #(
  parameter int MAX_SHAPES = 1048576
) (
  input logic             clk,
  input logic             rst,
  input logic             push,
  input logic             full,
  input logic             pop,
  input logic             empty,
  input nle_pkg::result_t result
);

  `NLE_ASSERT_ALWAYS(a_empty_after_reset, clk, rst |=> empty)
  `NLE_ASSERT_ALWAYS(a_room_after_reset, clk, rst |=> !full)
  `NLE_ASSERT(a_result_held, clk, rst, !empty && !pop |=> !empty && $stable(result))
  `NLE_ASSERT(a_no_shapes_zero_mean, clk, rst, !empty && result.shapes_seen == 21'd0 |-> result.mean_error == 32'd0)
  `NLE_ASSERT(a_shape_limit, clk, rst, !empty |-> result.shapes_seen <= 21'(MAX_SHAPES))

endmodule

bind normalized_landmark_error nle_checker #(.MAX_SHAPES(MAX_SHAPES)) u_nle_checker (
  .clk(clk), .rst(rst), .push(push), .full(full), .pop(pop), .empty(empty),
  .result(result)
);
